@@ rtl/segment_pair_similarity_macros.svh @@
// Assertion helpers shared by the segment pair similarity design.
`ifndef SEGMENT_PAIR_SIMILARITY_MACROS_SVH
`define SEGMENT_PAIR_SIMILARITY_MACROS_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define SPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sps_pkg.sv @@
package sps_pkg;

  // Configuration register widths and indexes.
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 8;
  localparam int LIM2_W = 2 * CFG_W;

  localparam logic [IDX_W-1:0] REG_DIST = 8'd0;
  localparam logic [IDX_W-1:0] REG_COS  = 8'd1;

  localparam logic [CFG_W-1:0] DIST_RESET = 16'd26;
  localparam logic [CFG_W-1:0] COS_RESET  = 16'd32767;

  // Fraction bits of the cosine limit.
  localparam int COS_FRAC = 15;

  // Register stages from a transfer to the stage results of each unit.
  localparam int UNIT_LATENCY = 6;

endpackage

@@ rtl/sps_near.sv @@
module sps_near #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                              clk,
  input  logic signed [COORD_WIDTH-1:0]     s0 [3],
  input  logic signed [COORD_WIDTH-1:0]     s1 [3],
  input  logic signed [COORD_WIDTH-1:0]     pt [3],
  input  logic        [sps_pkg::CFG_W-1:0]  lim,
  output logic                              near
);
  import sps_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 2;
  localparam int CRW = PW + 1;
  localparam int SQW = 2 * CRW;
  localparam int CW  = (SW > LIM2_W ? SW : LIM2_W) + 1;
  localparam int NW  = ((SQW + 2) > (LIM2_W + 1 + SW) ? (SQW + 2) : (LIM2_W + 1 + SW)) + 1;

  // Stage 1: edge vectors.
  logic signed [DW-1:0] ab [3];
  logic signed [DW-1:0] ac [3];
  logic signed [DW-1:0] bc [3];
  logic [CFG_W-1:0]     lim1;

  // Stage 2: products.
  logic signed [PW-1:0] pab [3];
  logic signed [PW-1:0] pdt [3];
  logic signed [PW-1:0] pea [3];
  logic signed [PW-1:0] peb [3];
  logic signed [PW-1:0] xa  [3];
  logic signed [PW-1:0] xb  [3];
  logic [LIM2_W-1:0]    lim2_2;

  // Stage 3: sums.
  logic signed [SW-1:0]  len3;
  logic signed [SW-1:0]  t3;
  logic signed [SW-1:0]  ea3;
  logic signed [SW-1:0]  eb3;
  logic signed [CRW-1:0] cr3 [3];
  logic [LIM2_W-1:0]     lim2_3;

  // Stage 4: squares and decisions.
  logic signed [SQW-1:0] sq4 [3];
  logic signed [NW-1:0]  lim_len4;
  logic                  inside4;
  logic                  ep4;

  // Stages 5 and 6: result.
  logic near5;
  logic near6;

  logic signed [CW-1:0] lim2_c;
  logic signed [NW-1:0] n_sum;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ab[i] <= DW'(s1[i]) - DW'(s0[i]);
      ac[i] <= DW'(pt[i]) - DW'(s0[i]);
      bc[i] <= DW'(pt[i]) - DW'(s1[i]);
    end
    lim1 <= lim;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pab[i] <= ab[i] * ab[i];
      pdt[i] <= ac[i] * ab[i];
      pea[i] <= ac[i] * ac[i];
      peb[i] <= bc[i] * bc[i];
    end
    // Cross product terms of (P-S0) x (S1-S0).
    xa[0] <= ac[1] * ab[2];
    xb[0] <= ac[2] * ab[1];
    xa[1] <= ac[2] * ab[0];
    xb[1] <= ac[0] * ab[2];
    xa[2] <= ac[0] * ab[1];
    xb[2] <= ac[1] * ab[0];
    lim2_2 <= lim1 * lim1;
  end

  always_ff @(posedge clk) begin
    len3 <= SW'(pab[0]) + SW'(pab[1]) + SW'(pab[2]);
    t3   <= SW'(pdt[0]) + SW'(pdt[1]) + SW'(pdt[2]);
    ea3  <= SW'(pea[0]) + SW'(pea[1]) + SW'(pea[2]);
    eb3  <= SW'(peb[0]) + SW'(peb[1]) + SW'(peb[2]);
    for (int i = 0; i < 3; i++) begin
      cr3[i] <= CRW'(xa[i]) - CRW'(xb[i]);
    end
    lim2_3 <= lim2_2;
  end

  assign lim2_c = CW'($signed({1'b0, lim2_3}));

  // The foot of the point falls strictly inside the segment when 0 < t < L.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq4[i] <= cr3[i] * cr3[i];
    end
    lim_len4 <= NW'($signed({1'b0, lim2_3})) * NW'(len3);
    inside4  <= (t3 > 0) && (len3 > t3);
    ep4      <= (CW'(ea3) < lim2_c) || (CW'(eb3) < lim2_c);
  end

  assign n_sum = NW'(sq4[0]) + NW'(sq4[1]) + NW'(sq4[2]);

  always_ff @(posedge clk) begin
    near5 <= inside4 ? (n_sum < lim_len4) : ep4;
    near6 <= near5;
  end

  assign near = near6;

endmodule

@@ rtl/sps_cross.sv @@
module sps_cross #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] az,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] bz,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cz,
  input  logic signed [COORD_WIDTH-1:0] dx,
  input  logic signed [COORD_WIDTH-1:0] dz,
  output logic                          crossing
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int OW  = PW + 1;

  // Stage 1: edge vectors in the x-z plane.
  logic signed [DW-1:0] ux, uz, vx, vz;
  logic signed [DW-1:0] acx, acz, adx, adz, cax, caz, cbx, cbz;

  // Stage 2: products.
  logic signed [PW-1:0] pc1, pc2;
  logic signed [PW-1:0] oa [4];
  logic signed [PW-1:0] ob [4];

  // Stage 3: signs.
  logic       nz3;
  logic [3:0] pos3;
  logic [3:0] neg3;

  // Stages 4 to 6.
  logic cr4, cr5, cr6;

  logic signed [OW-1:0] od [4];

  always_ff @(posedge clk) begin
    ux  <= DW'(bx) - DW'(ax);
    uz  <= DW'(bz) - DW'(az);
    vx  <= DW'(dx) - DW'(cx);
    vz  <= DW'(dz) - DW'(cz);
    acx <= DW'(cx) - DW'(ax);
    acz <= DW'(cz) - DW'(az);
    adx <= DW'(dx) - DW'(ax);
    adz <= DW'(dz) - DW'(az);
    cax <= DW'(ax) - DW'(cx);
    caz <= DW'(az) - DW'(cz);
    cbx <= DW'(bx) - DW'(cx);
    cbz <= DW'(bz) - DW'(cz);
  end

  always_ff @(posedge clk) begin
    pc1   <= ux * vz;
    pc2   <= uz * vx;
    oa[0] <= ux * acz;
    ob[0] <= uz * acx;
    oa[1] <= ux * adz;
    ob[1] <= uz * adx;
    oa[2] <= vx * caz;
    ob[2] <= vz * cax;
    oa[3] <= vx * cbz;
    ob[3] <= vz * cbx;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      od[k] = OW'(oa[k]) - OW'(ob[k]);
    end
  end

  // Orientation of each endpoint against the other segment's line.
  always_ff @(posedge clk) begin
    nz3 <= (pc1 != pc2);
    for (int k = 0; k < 4; k++) begin
      pos3[k] <= (od[k] > 0);
      neg3[k] <= (od[k] < 0);
    end
  end

  // Parallel projections never cross; otherwise neither pair may sit strictly on one side.
  always_ff @(posedge clk) begin
    cr4 <= nz3
        && !((pos3[0] && pos3[1]) || (neg3[0] && neg3[1]))
        && !((pos3[2] && pos3[3]) || (neg3[2] && neg3[3]));
    cr5 <= cr4;
    cr6 <= cr5;
  end

  assign crossing = cr6;

endmodule

@@ rtl/sps_angle.sv @@
module sps_angle #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                             clk,
  input  logic signed [COORD_WIDTH-1:0]    ax,
  input  logic signed [COORD_WIDTH-1:0]    az,
  input  logic signed [COORD_WIDTH-1:0]    bx,
  input  logic signed [COORD_WIDTH-1:0]    bz,
  input  logic signed [COORD_WIDTH-1:0]    cx,
  input  logic signed [COORD_WIDTH-1:0]    cz,
  input  logic signed [COORD_WIDTH-1:0]    dx,
  input  logic signed [COORD_WIDTH-1:0]    dz,
  input  logic        [sps_pkg::CFG_W-1:0] cos_lim,
  output logic                             aligned
);
  import sps_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  localparam int D2W = 2 * SW;
  localparam int CLW = LIM2_W + SW;
  localparam int HW  = CLW - LIM2_W;
  localparam int LOW = LIM2_W + SW;
  localparam int HIW = HW + SW;
  localparam int AW  = 2 * PW + 35;

  // Stage 1.
  logic signed [DW-1:0] ux, uz, vx, vz;
  logic [CFG_W-1:0]     cos1;

  // Stage 2.
  logic signed [PW-1:0] pd0, pd1, pu0, pu1, pv0, pv1;
  logic [LIM2_W-1:0]    cos2;

  // Stage 3.
  logic signed [SW-1:0] dot3;
  logic signed [SW-1:0] lu3s;
  logic signed [SW-1:0] lv3s;
  logic [LIM2_W-1:0]    cos2_3;

  // Stage 4.
  logic signed [D2W-1:0] dot2_4;
  logic [CLW-1:0]        cl4;
  logic [SW-1:0]         lv4;

  // Stage 5: the long product is split in two halves.
  logic [LOW-1:0]        lo5;
  logic [HIW-1:0]        hi5;
  logic signed [D2W-1:0] dot2_5;

  // Stage 6.
  logic ang6;

  logic [AW-1:0] rhs;
  logic [AW-1:0] lhs;

  always_ff @(posedge clk) begin
    ux   <= DW'(bx) - DW'(ax);
    uz   <= DW'(bz) - DW'(az);
    vx   <= DW'(dx) - DW'(cx);
    vz   <= DW'(dz) - DW'(cz);
    cos1 <= cos_lim;
  end

  always_ff @(posedge clk) begin
    pd0  <= ux * vx;
    pd1  <= uz * vz;
    pu0  <= ux * ux;
    pu1  <= uz * uz;
    pv0  <= vx * vx;
    pv1  <= vz * vz;
    cos2 <= cos1 * cos1;
  end

  always_ff @(posedge clk) begin
    dot3   <= SW'(pd0) + SW'(pd1);
    lu3s   <= SW'(pu0) + SW'(pu1);
    lv3s   <= SW'(pv0) + SW'(pv1);
    cos2_3 <= cos2;
  end

  // Squared lengths are never negative, so their bits are taken as unsigned.
  always_ff @(posedge clk) begin
    dot2_4 <= dot3 * dot3;
    cl4    <= CLW'(cos2_3) * CLW'($unsigned(lu3s));
    lv4    <= $unsigned(lv3s);
  end

  always_ff @(posedge clk) begin
    lo5    <= LOW'(cl4[LIM2_W-1:0]) * LOW'(lv4);
    hi5    <= HIW'(cl4[CLW-1:LIM2_W]) * HIW'(lv4);
    dot2_5 <= dot2_4;
  end

  assign rhs = (AW'(hi5) << LIM2_W) + AW'(lo5);
  assign lhs = AW'($unsigned(dot2_5)) << (2 * COS_FRAC);

  always_ff @(posedge clk) begin
    ang6 <= (rhs < lhs);
  end

  assign aligned = ang6;

endmodule

@@ rtl/segment_pair_similarity.sv @@
// Segment pair similarity test. A pair of 3D segments AB and CD is transferred
// when start is high and busy is low; busy never rises, so a new pair can be
// given on every clock cycle. Each pair produces one result: done is high for
// exactly one cycle, with similar and crossing valid alongside it, and the
// result is taken at the rising edge that ends that cycle; the receiver has to
// take it then. The pipeline depth is set by the angle unit, whose chain of
// squared products runs through six register stages, followed by the output
// register; the distance and crossing units are padded to the same depth. The
// configuration port is always ready, and its registers should be written only
// while no pair is in flight.
module segment_pair_similarity #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_WIDTH-1:0]    a_x,
  input  logic signed [COORD_WIDTH-1:0]    a_y,
  input  logic signed [COORD_WIDTH-1:0]    a_z,
  input  logic signed [COORD_WIDTH-1:0]    b_x,
  input  logic signed [COORD_WIDTH-1:0]    b_y,
  input  logic signed [COORD_WIDTH-1:0]    b_z,
  input  logic signed [COORD_WIDTH-1:0]    c_x,
  input  logic signed [COORD_WIDTH-1:0]    c_y,
  input  logic signed [COORD_WIDTH-1:0]    c_z,
  input  logic signed [COORD_WIDTH-1:0]    d_x,
  input  logic signed [COORD_WIDTH-1:0]    d_y,
  input  logic signed [COORD_WIDTH-1:0]    d_z,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic        [sps_pkg::IDX_W-1:0] cfg_index,
  input  logic        [sps_pkg::CFG_W-1:0] cfg_data,
  output logic                             done,
  output logic                             similar,
  output logic                             crossing
);
  import sps_pkg::*;

  `include "segment_pair_similarity_macros.svh"

  logic [CFG_W-1:0] distance_limit;
  logic [CFG_W-1:0] cos_angle_limit;

  logic [UNIT_LATENCY:0] vld;

  logic signed [COORD_WIDTH-1:0] pa [3];
  logic signed [COORD_WIDTH-1:0] pb [3];
  logic signed [COORD_WIDTH-1:0] pc [3];
  logic signed [COORD_WIDTH-1:0] pd [3];

  logic [3:0] near;
  logic       cross_hit;
  logic       aligned;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign pa = '{a_x, a_y, a_z};
  assign pb = '{b_x, b_y, b_z};
  assign pc = '{c_x, c_y, c_z};
  assign pd = '{d_x, d_y, d_z};

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit  <= DIST_RESET;
      cos_angle_limit <= COS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIST: distance_limit  <= cfg_data;
        REG_COS:  cos_angle_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits follow each transfer down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[UNIT_LATENCY-1:0], start && !busy};
    end
  end

  assign done = vld[UNIT_LATENCY];

  // Four point-to-segment distance tests.
  sps_near #(.COORD_WIDTH(COORD_WIDTH)) u_near_a (
    .clk(clk), .s0(pc), .s1(pd), .pt(pa), .lim(distance_limit), .near(near[0])
  );
  sps_near #(.COORD_WIDTH(COORD_WIDTH)) u_near_b (
    .clk(clk), .s0(pc), .s1(pd), .pt(pb), .lim(distance_limit), .near(near[1])
  );
  sps_near #(.COORD_WIDTH(COORD_WIDTH)) u_near_c (
    .clk(clk), .s0(pa), .s1(pb), .pt(pc), .lim(distance_limit), .near(near[2])
  );
  sps_near #(.COORD_WIDTH(COORD_WIDTH)) u_near_d (
    .clk(clk), .s0(pa), .s1(pb), .pt(pd), .lim(distance_limit), .near(near[3])
  );

  sps_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk(clk), .ax(a_x), .az(a_z), .bx(b_x), .bz(b_z),
    .cx(c_x), .cz(c_z), .dx(d_x), .dz(d_z), .crossing(cross_hit)
  );

  sps_angle #(.COORD_WIDTH(COORD_WIDTH)) u_angle (
    .clk(clk), .ax(a_x), .az(a_z), .bx(b_x), .bz(b_z),
    .cx(c_x), .cz(c_z), .dx(d_x), .dz(d_z),
    .cos_lim(cos_angle_limit), .aligned(aligned)
  );

  // Output register: crossing pairs are similar outright.
  always_ff @(posedge clk) begin
    similar  <= cross_hit || ((|near) && aligned);
    crossing <= cross_hit;
  end

  `SPS_ASSERT_SAME(a_cross_similar, done && crossing, similar, "crossing result not marked similar")
  `SPS_ASSERT_NEXT(a_cfg_dist, cfg_valid && cfg_ready && (cfg_index == REG_DIST), distance_limit == $past(cfg_data), "distance limit write lost")
  `SPS_ASSERT_NEXT(a_cfg_cos, cfg_valid && cfg_ready && (cfg_index == REG_COS), cos_angle_limit == $past(cfg_data), "cosine limit write lost")

endmodule

@@ sim/tb_segment_pair_similarity.sv @@
module tb_segment_pair_similarity;
  import sps_pkg::*;

  typedef logic signed [191:0] wide_t;
  typedef shortint pair_t[12];
  typedef longint pt_t[3];

  typedef struct {
    bit similar;
    bit crossing;
  } verdict_t;

  // Keeps its own copy of the two limits and the verdicts still owed by the block.
  class similarity_board;
    int unsigned dist_lim;
    int unsigned cos_lim;
    verdict_t owed[$];
    int errors;

    function new();
      dist_lim = DIST_RESET;
      cos_lim = COS_RESET;
      errors = 0;
    endfunction

    function void set_reg(int unsigned idx, int unsigned val);
      if (idx == REG_DIST) dist_lim = val & 16'hFFFF;
      else if (idx == REG_COS) cos_lim = val & 16'hFFFF;
    endfunction

    static function wide_t wm(wide_t x, wide_t y);
      return x * y;
    endfunction

    static function int sgn(wide_t w);
      if (w < 0) return -1;
      return (w != 0) ? 1 : 0;
    endfunction

    // Sign of (p - o) x (q - o) in the x-z plane.
    static function int orient(pt_t o, pt_t p, pt_t q);
      return sgn(wm(p[0] - o[0], q[2] - o[2]) - wm(p[2] - o[2], q[0] - o[0]));
    endfunction

    // True when point p lies closer than the limit to segment s0-s1.
    static function bit near_seg(pt_t s0, pt_t s1, pt_t p, wide_t lim2);
      longint ab[3], ac[3], bc[3];
      wide_t len, t, c0, c1, c2, n;
      for (int i = 0; i < 3; i++) begin
        ab[i] = s1[i] - s0[i];
        ac[i] = p[i] - s0[i];
        bc[i] = p[i] - s1[i];
      end
      len = wm(ab[0], ab[0]) + wm(ab[1], ab[1]) + wm(ab[2], ab[2]);
      t = wm(ac[0], ab[0]) + wm(ac[1], ab[1]) + wm(ac[2], ab[2]);
      if (t > 0 && len - t > 0) begin
        c0 = wm(ac[1], ab[2]) - wm(ac[2], ab[1]);
        c1 = wm(ac[2], ab[0]) - wm(ac[0], ab[2]);
        c2 = wm(ac[0], ab[1]) - wm(ac[1], ab[0]);
        n = c0 * c0 + c1 * c1 + c2 * c2;
        return n < lim2 * len;
      end
      return (wm(ac[0], ac[0]) + wm(ac[1], ac[1]) + wm(ac[2], ac[2]) < lim2) ||
             (wm(bc[0], bc[0]) + wm(bc[1], bc[1]) + wm(bc[2], bc[2]) < lim2);
    endfunction

    function verdict_t judge(pair_t item);
      pt_t pa, pb, pc, pd;
      longint ux, uz, vx, vz;
      wide_t lim2, dot, lhs, rhs, lu, lv, scale;
      verdict_t v;
      for (int i = 0; i < 3; i++) begin
        pa[i] = item[i];
        pb[i] = item[3 + i];
        pc[i] = item[6 + i];
        pd[i] = item[9 + i];
      end
      ux = pb[0] - pa[0];
      uz = pb[2] - pa[2];
      vx = pd[0] - pc[0];
      vz = pd[2] - pc[2];
      v.crossing = 0;
      v.similar = 0;
      // Parallel or degenerate projections never count as crossing.
      if (wm(ux, vz) - wm(uz, vx) != 0)
        v.crossing = (orient(pa, pb, pc) * orient(pa, pb, pd) <= 0) &&
                     (orient(pc, pd, pa) * orient(pc, pd, pb) <= 0);
      if (v.crossing) begin
        v.similar = 1;
      end else begin
        lim2 = wm(dist_lim, dist_lim);
        if (near_seg(pc, pd, pa, lim2) || near_seg(pc, pd, pb, lim2) ||
            near_seg(pa, pb, pc, lim2) || near_seg(pa, pb, pd, lim2)) begin
          scale = 1;
          scale = scale << (2 * COS_FRAC);
          dot = wm(ux, vx) + wm(uz, vz);
          lhs = dot * dot * scale;
          lu = wm(ux, ux) + wm(uz, uz);
          lv = wm(vx, vx) + wm(vz, vz);
          rhs = wm(cos_lim, cos_lim) * lu * lv;
          v.similar = rhs < lhs;
        end
      end
      return v;
    endfunction

    function void note(pair_t item);
      owed.insert(owed.size(), judge(item));
    endfunction

    function void check(logic sim, logic cr);
      verdict_t e;
      if (owed.size() == 0) begin
        $error("unexpected result: similar %0d crossing %0d", sim, cr);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (sim !== e.similar) begin
        $error("similar: expected %0d, actual %0d", e.similar, sim);
        errors++;
      end
      if (cr !== e.crossing) begin
        $error("crossing: expected %0d, actual %0d", e.crossing, cr);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [15:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
  logic signed [15:0] c_x = 0, c_y = 0, c_z = 0, d_x = 0, d_y = 0, d_z = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;
  logic done, similar, crossing;
  bit calm = 0;
  similarity_board board = new();

  segment_pair_similarity dut (
    .clk, .rst, .start, .busy,
    .a_x, .a_y, .a_z, .b_x, .b_y, .b_z, .c_x, .c_y, .c_z, .d_x, .d_y, .d_z,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .done, .similar, .crossing
  );

  always #5 clk = ~clk;

  // Results cannot be held off, so each strobe is checked on the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done) board.check(similar, crossing);
  end

  // Idle for a random burst now and then, unless the run is in its calm tail.
  task automatic maybe_idle();
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 12);
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send(pair_t item);
    maybe_idle();
    {a_x, a_y, a_z} <= {item[0], item[1], item[2]};
    {b_x, b_y, b_z} <= {item[3], item[4], item[5]};
    {c_x, c_y, c_z} <= {item[6], item[7], item[8]};
    {d_x, d_y, d_z} <= {item[9], item[10], item[11]};
    start <= 1;
    do @(posedge clk); while (busy);
    board.note(item);
  endtask

  // Drains the pipeline before touching the limits.
  task automatic settle();
    start <= 0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(int unsigned idx, int unsigned val);
    settle();
    cfg_index <= IDX_W'(idx);
    cfg_data <= CFG_W'(val);
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.set_reg(idx, val);
  endtask

  task automatic make_pair(ref pair_t item);
    int spread, base;
    if ($urandom_range(0, 3) == 0) begin
      foreach (item[i]) item[i] = shortint'($urandom);
      return;
    end
    // Local pairs so that the distance and angle tests are reached.
    case ($urandom_range(0, 2))
      0: spread = 16;
      1: spread = 256;
      default: spread = 4096;
    endcase
    for (int k = 0; k < 3; k++) begin
      base = $signed(16'($urandom));
      for (int p = 0; p < 4; p++)
        item[p * 3 + k] = shortint'(base + $urandom_range(0, 2 * spread) - spread);
    end
    // Often make CD a shifted copy of AB so that the angle test passes.
    if ($urandom_range(0, 1) == 0) begin
      for (int k = 0; k < 3; k++) begin
        base = $urandom_range(0, 2 * spread / 8) - spread / 8;
        item[6 + k] = shortint'(item[k] + base + $urandom_range(0, 2) - 1);
        item[9 + k] = shortint'(item[3 + k] + base + $urandom_range(0, 2) - 1);
      end
    end
  endtask

  task automatic directed();
    send('{-32768, -32768, -32768, -32768, -32768, -32768,
           -32768, -32768, -32768, -32768, -32768, -32768});
    send('{32767, 32767, 32767, 32767, 32767, 32767,
           32767, 32767, 32767, 32767, 32767, 32767});
    send('{-32768, 0, -32768, 32767, 0, 32767, -32768, 0, 32767, 32767, 0, -32768});
    send('{-32768, 32767, -32768, 32767, -32768, 32767,
           -32768, -32768, -32767, 32767, 32767, 32767});
    // Plain crossing, touching endpoints, and a T junction.
    send('{0, 0, 0, 512, 0, 512, 0, 100, 512, 512, -100, 0});
    send('{0, 0, 0, 512, 0, 0, 512, 0, 0, 512, 0, 512});
    send('{0, 0, 0, 512, 0, 0, 256, 0, 0, 256, 0, 512});
    // Parallel, collinear overlapping, and near parallel segments.
    send('{0, 0, 0, 512, 0, 0, 0, 0, 10, 512, 0, 10});
    send('{0, 0, 0, 512, 0, 0, 100, 0, 0, 600, 0, 0});
    send('{0, 0, 0, 512, 0, 0, 0, 5, 20, 512, 5, 21});
    send('{0, 0, 0, 512, 0, 0, 0, 0, 30, 512, 0, 30});
    // Zero-length segments, and segments vertical in x-z.
    send('{7, 7, 7, 7, 7, 7, 10, 10, 10, 10, 10, 10});
    send('{0, 0, 0, 0, 0, 0, -50, 5, 10, 50, 5, 10});
    send('{0, 0, 0, 0, 900, 0, 5, 0, 5, 5, 900, 5});
    // Foot of the point inside the other segment, and beyond its end.
    send('{0, 0, 0, 1000, 0, 0, 500, 12, 0, 1500, 12, 1});
    send('{0, 0, 0, 1000, 0, 0, 1010, 0, 1, 2000, 0, 2});
    send('{0, 0, 0, 1000, 0, 0, 0, 0, 20, 0, 0, 900});
  endtask

  task automatic random_phase(int n);
    pair_t item;
    repeat (n) begin
      make_pair(item);
      send(item);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    directed();
    random_phase(380);
    write_reg(REG_DIST, 0);
    write_reg(REG_COS, 0);
    directed();
    random_phase(300);
    write_reg(REG_DIST, 16'hFFFF);
    write_reg(REG_COS, 32768);
    random_phase(300);
    write_reg(REG_COS, 16'hFFFF);
    write_reg(8'hA5, 16'h1234);
    random_phase(200);
    write_reg(REG_DIST, $urandom_range(0, 2000));
    write_reg(REG_COS, $urandom_range(25000, 32767));
    random_phase(350);
    write_reg(REG_DIST, $urandom);
    write_reg(REG_COS, $urandom);
    calm = 1;
    random_phase(380);
    settle();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
